>>> hdl/blcr_pkg.sv
// Package for the Bresenham line color rasterizer.
// Holds the coordinate width, the default weight precision, request codes and word types.
// No dependencies.
`default_nettype none

package blcr_pkg;

    localparam int COORD_BITS       = 12;
    localparam int WEIGHT_FRAC_BITS = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        delta_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic        req_type;
        coord_t      start_x;
        coord_t      start_y;
        coord_t      end_x;
        coord_t      end_y;
        logic [31:0] start_rgba;
        logic [31:0] end_rgba;
    } in_word_t;

    typedef struct packed {
        logic        pixel_valid;
        coord_t      pixel_x;
        coord_t      pixel_y;
        logic [31:0] pixel_rgba;
        logic        last_pixel;
    } out_word_t;

endpackage

`default_nettype wire

>>> hdl/blcr_weight_div.sv
// Iterative restoring divider for the blend weight, one quotient bit per cycle.
// Produces floor(num * 2^FRAC_BITS / den), clamped to 1.0, or zero for a zero divisor.
// No package dependencies.
`default_nettype none

module blcr_weight_div #(
    parameter int DEN_BITS  = 12,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DEN_BITS-1:0]  num,
    input  wire logic [DEN_BITS-1:0]  den,
    output logic                      done,
    output logic [FRAC_BITS:0]        weight
);

    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [FRAC_BITS:0]  quo_reg;

    logic [DEN_BITS:0] rem_shift;
    logic [DEN_BITS:0] rem_sub;
    logic              fits;

    always_comb begin
        rem_shift = {rem_reg, 1'b0};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= start ? ((den == '0) || (num >= den))
                              : (busy_reg && (cnt_reg == CNT_BITS'(1)));
            if (start) begin
                den_reg <= den;
                rem_reg <= num;
                cnt_reg <= CNT_BITS'(FRAC_BITS);
                if (den == '0) begin
                    quo_reg <= '0;
                end else if (num >= den) begin
                    quo_reg <= {1'b1, {FRAC_BITS{1'b0}}};
                end else begin
                    quo_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sub[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
                quo_reg <= {quo_reg[FRAC_BITS-1:0], fits};
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done   = done_reg;
    assign weight = quo_reg;

endmodule

`default_nettype wire

>>> hdl/blcr_color_mix.sv
// Color blender that runs the four 8-bit channels through one shared multiplier in turn.
// Each channel is a + (b - a) * w, truncated by FRAC_BITS. No package dependencies.
`default_nettype none

module blcr_color_mix #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [FRAC_BITS:0] weight,
    input  wire logic [31:0]        color_a,
    input  wire logic [31:0]        color_b,
    output logic                    done,
    output logic [31:0]             rgba
);

    logic               busy_reg;
    logic               done_reg;
    logic [1:0]         ch_reg;
    logic [FRAC_BITS:0] w_reg;
    logic [31:0]        ca_reg;
    logic [31:0]        cb_reg;
    logic [31:0]        rgba_reg;

    logic [7:0]                  chan_a;
    logic [7:0]                  chan_b;
    logic signed [8:0]           diff;
    logic signed [FRAC_BITS+1:0] w_s;
    logic signed [FRAC_BITS+10:0] prod;
    logic signed [FRAC_BITS+10:0] base;
    logic signed [FRAC_BITS+10:0] sum;
    logic [7:0]                  chan_out;

    always_comb begin
        chan_a   = ca_reg[{ch_reg, 3'b000} +: 8];
        chan_b   = cb_reg[{ch_reg, 3'b000} +: 8];
        diff     = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
        w_s      = $signed({1'b0, w_reg});
        prod     = diff * w_s;
        base     = $signed({3'b000, chan_a, {FRAC_BITS{1'b0}}});
        sum      = base + prod;
        chan_out = sum[FRAC_BITS+7:FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && (ch_reg == 2'd3);
            if (start) begin
                busy_reg <= 1'b1;
                ch_reg   <= 2'd0;
                w_reg    <= weight;
                ca_reg   <= color_a;
                cb_reg   <= color_b;
            end else if (busy_reg) begin
                rgba_reg[{ch_reg, 3'b000} +: 8] <= chan_out;
                ch_reg <= ch_reg + 2'd1;
                if (ch_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign rgba = rgba_reg;

endmodule

`default_nettype wire

>>> hdl/bresenham_line_color_rasterizer_top.sv
// Top level of the Bresenham line color rasterizer: line setup, stepping and sequencer.
// Depends on blcr_pkg, blcr_weight_div and blcr_color_mix.
//
//   Channel   Ports                        Word
//   input     s_valid, s_ready, s_data     blcr_pkg::in_word_t (load or step request)
//   result    m_valid, m_ready, m_data     blcr_pkg::out_word_t (one per step request)
//
// A load request gives no result.
// A step on an active line runs the weight divider's one-bit-per-cycle loop and then the
// four passes of the shared channel multiplier.
// A step with no active line gives an empty word. Reset is synchronous and clears the line.
// A result waits in the output register while the next request is accepted.
`default_nettype none

module bresenham_line_color_rasterizer_top #(
    parameter int WEIGHT_FRAC_BITS = blcr_pkg::WEIGHT_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire blcr_pkg::in_word_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output blcr_pkg::out_word_t       m_data
);

    localparam int CB       = blcr_pkg::COORD_BITS;
    localparam int ERR_BITS = CB + 3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MIX  = 4'b0100,
        ST_PUSH = 4'b1000
    } seq_state_t;

    function automatic blcr_pkg::delta_t abs_diff(input blcr_pkg::coord_t a,
                                                  input blcr_pkg::coord_t b);
        logic signed [CB:0] d;
        logic signed [CB:0] nd;
        d  = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
        nd = -d;
        return d[CB] ? nd[CB-1:0] : d[CB-1:0];
    endfunction

    function automatic blcr_pkg::coord_t step_one(input blcr_pkg::coord_t c,
                                                  input logic neg);
        return neg ? c - blcr_pkg::coord_t'(1) : c + blcr_pkg::coord_t'(1);
    endfunction

    seq_state_t state_reg;

    logic                   line_active_reg;
    blcr_pkg::coord_t       cur_x_reg, cur_y_reg;
    blcr_pkg::coord_t       stop_x_reg, stop_y_reg;
    blcr_pkg::coord_t       origin_x_reg, origin_y_reg;
    logic signed [ERR_BITS-1:0] err_reg;
    logic [CB:0]            twice_dx_reg, twice_dy_reg;
    logic                   x_major_reg;
    logic                   step_x_neg_reg, step_y_neg_reg;
    logic                   blend_on_x_reg;
    blcr_pkg::delta_t       blend_recip_reg;
    logic [31:0]            color_a_reg, color_b_reg;

    blcr_pkg::out_word_t    res_reg;
    blcr_pkg::out_word_t    out_reg;
    logic                   m_valid_reg;

    logic accept;
    logic out_free;

    blcr_pkg::delta_t       ld_adx, ld_ady;
    logic                   ld_x_major;
    logic                   ld_blend_on_x;

    blcr_pkg::delta_t       st_num;
    logic signed [ERR_BITS-1:0] tdx_s, tdy_s;
    logic signed [ERR_BITS-1:0] err_add, err_next;
    logic                   bump;
    blcr_pkg::coord_t       cur_x_next, cur_y_next;
    logic                   last_next;

    logic                   div_start;
    logic                   div_done;
    logic [WEIGHT_FRAC_BITS:0] div_weight;
    logic                   mix_start;
    logic                   mix_done;
    logic [31:0]            mix_rgba;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        ld_adx        = abs_diff(s_data.end_x, s_data.start_x);
        ld_ady        = abs_diff(s_data.end_y, s_data.start_y);
        ld_x_major    = ld_adx > ld_ady;
        ld_blend_on_x = (s_data.start_y == s_data.end_y);
    end

    always_comb begin
        st_num  = blend_on_x_reg ? abs_diff(cur_x_reg, origin_x_reg)
                                 : abs_diff(cur_y_reg, origin_y_reg);
        tdx_s   = $signed({2'b00, twice_dx_reg});
        tdy_s   = $signed({2'b00, twice_dy_reg});
        err_add = err_reg + (x_major_reg ? tdy_s : tdx_s);
        bump    = err_add > 0;
        err_next = bump ? err_add - (x_major_reg ? tdx_s : tdy_s) : err_add;
        if (x_major_reg) begin
            cur_x_next = step_one(cur_x_reg, step_x_neg_reg);
            cur_y_next = bump ? step_one(cur_y_reg, step_y_neg_reg) : cur_y_reg;
            last_next  = (cur_x_next == stop_x_reg);
        end else begin
            cur_y_next = step_one(cur_y_reg, step_y_neg_reg);
            cur_x_next = bump ? step_one(cur_x_reg, step_x_neg_reg) : cur_x_reg;
            last_next  = (cur_y_next == stop_y_reg);
        end
    end

    assign div_start = accept && (s_data.req_type == blcr_pkg::REQ_STEP) && line_active_reg;
    assign mix_start = (state_reg == ST_DIV) && div_done;

    blcr_weight_div #(
        .DEN_BITS  (CB),
        .FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (st_num),
        .den     (blend_recip_reg),
        .done    (div_done),
        .weight  (div_weight)
    );

    blcr_color_mix #(
        .FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .weight  (div_weight),
        .color_a (color_a_reg),
        .color_b (color_b_reg),
        .done    (mix_done),
        .rgba    (mix_rgba)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            line_active_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_PUSH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_data.req_type == blcr_pkg::REQ_LOAD) begin
                            step_x_neg_reg  <= !(s_data.end_x > s_data.start_x);
                            step_y_neg_reg  <= !(s_data.end_y > s_data.start_y);
                            twice_dx_reg    <= {ld_adx, 1'b0};
                            twice_dy_reg    <= {ld_ady, 1'b0};
                            cur_x_reg       <= s_data.start_x;
                            cur_y_reg       <= s_data.start_y;
                            origin_x_reg    <= s_data.start_x;
                            origin_y_reg    <= s_data.start_y;
                            stop_x_reg      <= s_data.end_x;
                            stop_y_reg      <= s_data.end_y;
                            x_major_reg     <= ld_x_major;
                            err_reg         <= -$signed({3'b000,
                                                         ld_x_major ? ld_adx : ld_ady});
                            blend_on_x_reg  <= ld_blend_on_x;
                            blend_recip_reg <= ld_blend_on_x ? ld_adx : ld_ady;
                            color_a_reg     <= s_data.start_rgba;
                            color_b_reg     <= s_data.end_rgba;
                            line_active_reg <= ld_x_major
                                               ? (s_data.start_x != s_data.end_x)
                                               : (s_data.start_y != s_data.end_y);
                        end else if (line_active_reg) begin
                            res_reg.pixel_valid <= 1'b1;
                            res_reg.pixel_x     <= cur_x_reg;
                            res_reg.pixel_y     <= cur_y_reg;
                            res_reg.last_pixel  <= last_next;
                            cur_x_reg           <= cur_x_next;
                            cur_y_reg           <= cur_y_next;
                            err_reg             <= err_next;
                            if (last_next) begin
                                line_active_reg <= 1'b0;
                            end
                            state_reg <= ST_DIV;
                        end else begin
                            res_reg   <= '0;
                            state_reg <= ST_PUSH;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    if (mix_done) begin
                        res_reg.pixel_rgba <= mix_rgba;
                        state_reg          <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        out_reg     <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

>>> sim/tb_bresenham_line_color_rasterizer_top.sv
// Self-checking testbench for bresenham_line_color_rasterizer_top.
// Drives load and step request words, predicts every pixel word and checks each field.
// Depends on blcr_pkg and the rasterizer RTL.
`timescale 1ns / 100ps

module tb_bresenham_line_color_rasterizer_top;

    localparam int CLK_HALF     = 4;
    localparam int WFRAC        = blcr_pkg::WEIGHT_FRAC_BITS;
    localparam int RANDOM_ITEMS = 720;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    blcr_pkg::in_word_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    blcr_pkg::out_word_t m_data;

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    int n_fail  = 0;
    int n_loads = 0;
    int n_steps = 0;
    int n_words = 0;
    int n_empty = 0;

    blcr_pkg::out_word_t exp_pixels[$];
    blcr_pkg::out_word_t want_px;

    blcr_pkg::coord_t ln_cur_x = '0, ln_cur_y = '0, ln_stop_x = '0, ln_stop_y = '0;
    blcr_pkg::coord_t ln_org_x = '0, ln_org_y = '0;
    int          ln_err = 0, ln_2dx = 0, ln_2dy = 0, ln_div = 0;
    bit          ln_live = 1'b0, ln_xmaj = 1'b0, ln_xneg = 1'b0, ln_yneg = 1'b0;
    bit          ln_blend_x = 1'b0;
    logic [31:0] ln_col_a = '0, ln_col_b = '0;

    bresenham_line_color_rasterizer_top #(
        .WEIGHT_FRAC_BITS(WFRAC)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [31:0] mix_color(int num, int den);
        longint unsigned one, w, a, b, c;
        logic [31:0]     res;
        int              sh;
        one = 64'd1 << WFRAC;
        w   = 0;
        res = '0;
        if (den > 0) begin
            w = (longint'(num) << WFRAC) / longint'(den);
            if (w > one) begin
                w = one;
            end
        end
        for (sh = 0; sh < 32; sh += 8) begin
            a = (ln_col_a >> sh) & 32'hFF;
            b = (ln_col_b >> sh) & 32'hFF;
            c = (a * (one - w) + b * w) >> WFRAC;
            res[sh +: 8] = c[7:0];
        end
        return res;
    endfunction

    function automatic void rasterize_request(blcr_pkg::in_word_t w);
        int                  sx, sy, ex, ey, dx, dy, adx, ady, num, ux, uy;
        bit                  last;
        blcr_pkg::out_word_t px;
        if (w.req_type == blcr_pkg::REQ_LOAD) begin
            sx  = w.start_x;
            sy  = w.start_y;
            ex  = w.end_x;
            ey  = w.end_y;
            dx  = ex - sx;
            dy  = ey - sy;
            adx = abs_int(dx);
            ady = abs_int(dy);
            ln_xneg    = !(dx > 0);
            ln_yneg    = !(dy > 0);
            ln_2dx     = 2 * adx;
            ln_2dy     = 2 * ady;
            ln_cur_x   = w.start_x;
            ln_cur_y   = w.start_y;
            ln_org_x   = w.start_x;
            ln_org_y   = w.start_y;
            ln_stop_x  = w.end_x;
            ln_stop_y  = w.end_y;
            ln_xmaj    = adx > ady;
            ln_err     = ln_xmaj ? -adx : -ady;
            ln_blend_x = (sy == ey);
            ln_div     = ln_blend_x ? adx : ady;
            ln_col_a   = w.start_rgba;
            ln_col_b   = w.end_rgba;
            ln_live    = ln_xmaj ? (sx != ex) : (sy != ey);
            return;
        end
        px = '0;
        if (ln_live) begin
            num = ln_blend_x ? abs_int(int'(ln_cur_x) - int'(ln_org_x))
                             : abs_int(int'(ln_cur_y) - int'(ln_org_y));
            ux  = ln_xneg ? -1 : 1;
            uy  = ln_yneg ? -1 : 1;
            px.pixel_valid = 1'b1;
            px.pixel_x     = ln_cur_x;
            px.pixel_y     = ln_cur_y;
            px.pixel_rgba  = mix_color(num, ln_div);
            if (ln_xmaj) begin
                ln_cur_x = blcr_pkg::coord_t'(int'(ln_cur_x) + ux);
                ln_err   = ln_err + ln_2dy;
                if (ln_err > 0) begin
                    ln_cur_y = blcr_pkg::coord_t'(int'(ln_cur_y) + uy);
                    ln_err   = ln_err - ln_2dx;
                end
                last = (ln_cur_x == ln_stop_x);
            end else begin
                ln_cur_y = blcr_pkg::coord_t'(int'(ln_cur_y) + uy);
                ln_err   = ln_err + ln_2dx;
                if (ln_err > 0) begin
                    ln_cur_x = blcr_pkg::coord_t'(int'(ln_cur_x) + ux);
                    ln_err   = ln_err - ln_2dy;
                end
                last = (ln_cur_y == ln_stop_y);
            end
            if (last) begin
                ln_live = 1'b0;
            end
            px.last_pixel = last;
        end
        exp_pixels.push_back(px);
    endfunction

    function automatic blcr_pkg::in_word_t random_word();
        blcr_pkg::in_word_t w;
        w.req_type   = 1'($urandom);
        w.start_x    = blcr_pkg::coord_t'($urandom);
        w.start_y    = blcr_pkg::coord_t'($urandom);
        w.end_x      = blcr_pkg::coord_t'($urandom);
        w.end_y      = blcr_pkg::coord_t'($urandom);
        w.start_rgba = $urandom;
        w.end_rgba   = $urandom;
        return w;
    endfunction

    function automatic blcr_pkg::coord_t pick_end(blcr_pkg::coord_t s, int lim);
        int d, e;
        d = $urandom_range(0, 2 * lim) - lim;
        e = int'(s) + d;
        if (e > 2047 || e < -2048) begin
            e = int'(s) - d;
        end
        return blcr_pkg::coord_t'(e);
    endfunction

    // The caller is just past a falling edge; valid is left high after acceptance so that
    // back-to-back words never lower and raise it in one time step.
    task automatic send_word(blcr_pkg::in_word_t w);
        while (idle_on && $urandom_range(0, 99) < 17) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        rasterize_request(w);
        if (w.req_type == blcr_pkg::REQ_LOAD) begin
            n_loads++;
        end else begin
            n_steps++;
        end
        @(negedge aclk);
    endtask

    task automatic load_line(int sx, int sy, int ex, int ey, logic [31:0] ca, logic [31:0] cb);
        blcr_pkg::in_word_t w;
        w            = random_word();
        w.req_type   = blcr_pkg::REQ_LOAD;
        w.start_x    = blcr_pkg::coord_t'(sx);
        w.start_y    = blcr_pkg::coord_t'(sy);
        w.end_x      = blcr_pkg::coord_t'(ex);
        w.end_y      = blcr_pkg::coord_t'(ey);
        w.start_rgba = ca;
        w.end_rgba   = cb;
        send_word(w);
    endtask

    task automatic step_pixel();
        blcr_pkg::in_word_t w;
        w          = random_word();
        w.req_type = blcr_pkg::REQ_STEP;
        send_word(w);
    endtask

    task automatic test_directed();
        step_pixel();
        load_line(0, 0, 0, 0, $urandom, $urandom);
        step_pixel();
        load_line(-2048, -2048, 2047, 2047, 32'h0000_0000, 32'hFFFF_FFFF);
        step_pixel();
        step_pixel();
        load_line(2047, 5, -2048, 5, 32'hFFFF_FFFF, 32'h0000_0000);
        step_pixel();
        step_pixel();
        load_line(3, -2048, 3, 2047, $urandom, $urandom);
        step_pixel();
        load_line(0, 0, 2, -1, $urandom, $urandom);
        repeat (3) step_pixel();
        load_line(5, 5, 4, 8, $urandom, $urandom);
        repeat (4) step_pixel();
        load_line(10, 10, 7, 7, 32'h00FF_00FF, 32'hFF00_FF00);
        repeat (4) step_pixel();
    endtask

    task automatic test_random_lines();
        int                 sent, mode, span, steps, r;
        blcr_pkg::in_word_t w;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = !(sent >= 300 && sent < 450);
            mode    = $urandom_range(0, 99);
            if (mode < 8) begin
                send_word(random_word());
                sent++;
            end else begin
                w          = random_word();
                w.req_type = blcr_pkg::REQ_LOAD;
                if (mode >= 18) begin
                    r       = ($urandom_range(0, 4) == 0) ? 64 : 8;
                    w.end_x = pick_end(w.start_x, r);
                    w.end_y = pick_end(w.start_y, r);
                end
                span = abs_int(int'(w.end_x) - int'(w.start_x));
                if (abs_int(int'(w.end_y) - int'(w.start_y)) > span) begin
                    span = abs_int(int'(w.end_y) - int'(w.start_y));
                end
                if (mode < 18) begin
                    steps = $urandom_range(1, 12);
                end else begin
                    r = $urandom_range(0, 9);
                    if (r == 0) begin
                        steps = span + $urandom_range(1, 2);
                    end else if (r == 1) begin
                        steps = $urandom_range(0, span);
                    end else begin
                        steps = span;
                    end
                end
                send_word(w);
                repeat (steps) step_pixel();
                sent += 1 + steps;
            end
        end
        idle_on = 1'b1;
    endtask

    // The receiver stalls for a long stretch while step words keep coming, so the block
    // fills up and holds off its input.
    task automatic test_backpressure();
        hold_req = 1'b1;
        load_line(-100, 7, 100, 30, $urandom, $urandom);
        repeat (40) step_pixel();
        wait (!hold_req);
        @(negedge aclk);
    endtask

    task automatic finish_run();
        int i;
        s_valid <= 1'b0;
        for (i = 0; i < 20000 && exp_pixels.size() != 0; i++) begin
            @(posedge aclk);
        end
        if (exp_pixels.size() != 0) begin
            $error("%0d expected pixel words never arrived", exp_pixels.size());
            n_fail += exp_pixels.size();
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d line loads and %0d step requests, including overruns and reloads.",
                 n_loads, n_steps);
        $display("Checked %0d result words, %0d of them empty.", n_words, n_empty);
        if (n_fail == 0) begin
            $display("bresenham_line_color_rasterizer_top verification clean");
        end else begin
            $display("bresenham_line_color_rasterizer_top verification failed");
        end
        $finish;
    endtask

    function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
            n_fail++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (exp_pixels.size() == 0) begin
                $error("result word %h arrived with nothing expected", m_data);
                n_fail++;
            end else begin
                want_px = exp_pixels.pop_front();
                check_field("pixel_valid", want_px.pixel_valid, m_data.pixel_valid);
                check_field("pixel_x", want_px.pixel_x, m_data.pixel_x);
                check_field("pixel_y", want_px.pixel_y, m_data.pixel_y);
                check_field("pixel_rgba", want_px.pixel_rgba, m_data.pixel_rgba);
                check_field("last_pixel", want_px.last_pixel, m_data.last_pixel);
                n_words++;
                if (!want_px.pixel_valid) begin
                    n_empty++;
                end
            end
        end
    end

    initial begin
        int i;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (i = 0; i < HOLD_CYCLES; i++) begin
                    @(negedge aclk);
                end
                hold_req = 1'b0;
            end else begin
                m_ready <= !(idle_on && $urandom_range(0, 99) < 17);
            end
        end
    end

    initial begin
        #5000000;
        $display("bresenham_line_color_rasterizer_top verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_lines();
        test_backpressure();
        finish_run();
    end

endmodule
